>>> src/assert_macros.svh
// Assertion macros for the top-level RTL file of the ionization yield block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LYI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LYI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lyi_pkg.sv
// Package with types, constants and table functions of the ionization yield block.
`timescale 1ns / 1ps

package lyi_pkg;

    // Default sizes.
    localparam int LYI_ENERGY_BITS = 20;
    localparam int LYI_LOG_DEPTH   = 64;

    // Fixed field and datapath widths.
    localparam int LYI_ADDR_W  = 5;
    localparam int LYI_DATA_W  = 32;
    localparam int LYI_Y_W     = 16;
    localparam int LYI_DEP_W   = 28;
    localparam int LYI_LOG_W   = 17;
    localparam int LYI_EXP_W   = 18;
    localparam int LYI_LG_W    = 24;
    localparam int LYI_V_W     = 25;
    localparam int LYI_IP_W    = 9;
    localparam int LYI_PWR_W   = 57;
    localparam int LYI_G_W     = 50;
    localparam int LYI_KG_W    = 50;
    localparam int LYI_NUM_W   = 64;
    localparam int LYI_DEN_W   = 49;
    localparam int LYI_Q_STEPS = 16;

    // Pipeline depth: fifteen datapath stages, then the divider setup and its steps.
    localparam int LYI_DIV_LAT  = LYI_Q_STEPS + 1;
    localparam int LYI_LANE_LAT = 15 + LYI_DIV_LAT;

    localparam logic [LYI_G_W-1:0]   LYI_G_CAP   = '1;
    localparam logic [LYI_DEP_W-1:0] LYI_DEP_MAX = '1;

    // Register reset values.
    localparam logic [15:0] LYI_K_RST       = 16'd10420;
    localparam logic [23:0] LYI_SCALE_RST   = 24'd15196;
    localparam logic [15:0] LYI_COEF_A_RST  = 16'd12288;
    localparam logic [15:0] LYI_POWER_A_RST = 16'd9830;
    localparam logic [15:0] LYI_COEF_B_RST  = 16'd2867;
    localparam logic [15:0] LYI_POWER_B_RST = 16'd39322;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        LYI_REG_K       = 3'd0,
        LYI_REG_SCALE   = 3'd1,
        LYI_REG_COEF_A  = 3'd2,
        LYI_REG_POWER_A = 3'd3,
        LYI_REG_COEF_B  = 3'd4,
        LYI_REG_POWER_B = 3'd5
    } t_reg_idx;

    // Configuration values handed to the datapath.
    typedef struct packed {
        logic [15:0] k;
        logic [23:0] scale;
        logic [15:0] coef_a;
        logic [15:0] power_a;
        logic [15:0] coef_b;
        logic [15:0] power_b;
    } t_cfg;

    // One result as it waits at the output.
    typedef struct packed {
        logic [LYI_Y_W-1:0]   start_yield;
        logic [LYI_Y_W-1:0]   end_yield;
        logic [LYI_DEP_W-1:0] dep;
        logic                 err;
    } t_result;

    // log2(y / 2^16) in Q1.16 for y in [2^16, 2^17], found bit by bit by squaring.
    function automatic logic [LYI_LOG_W-1:0] lyi_frac_log2(input logic [31:0] y);
        logic [63:0]          x;
        logic [LYI_LOG_W-1:0] r;
        int                   i;
        r = '0;
        if (y >= 32'd131072) return 17'd65536;
        if (y < 32'd65536) return 17'd0;
        x = {18'd0, y, 14'd0};
        for (i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            r = {r[15:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return r;
    endfunction

    // Log table entry for the mantissa step t.
    function automatic logic [LYI_LOG_W-1:0] lyi_log_entry(input int t);
        return lyi_frac_log2(32'(65536 + t));
    endfunction

    // Exp table entry: largest mantissa whose log does not exceed t, in Q2.16.
    function automatic logic [LYI_EXP_W-1:0] lyi_exp_entry(input int t);
        int lo;
        int hi;
        int mid;
        int j;
        lo = 0;
        hi = 65536;
        for (j = 0; j < 18; j++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (int'(lyi_frac_log2(32'(65536 + mid))) <= t) lo = mid;
                else hi = mid - 1;
            end
        end
        return LYI_EXP_W'(65536 + lo);
    endfunction

endpackage

>>> src/lyi_div.sv
// Pipelined restoring divider that turns k*g into the Lindhard yield.
`timescale 1ns / 1ps

module lyi_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lyi_pkg::LYI_KG_W-1:0] i_kg,
    output logic [lyi_pkg::LYI_Y_W-1:0]  o_quot
);
    import lyi_pkg::*;

    logic [LYI_NUM_W-1:0] r_num [0:LYI_Q_STEPS];
    logic [LYI_DEN_W-1:0] r_den [0:LYI_Q_STEPS-1];
    logic [LYI_Y_W-1:0]   r_quo [1:LYI_Q_STEPS];

    // Setup: dividend kg*2^14 and divisor (2^32 + kg) / 4.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {i_kg, 14'd0};
            r_den[0] <= LYI_DEN_W'((51'(i_kg) + (51'(1) << 32)) >> 2);
        end
    end

    // One quotient bit per stage, most significant first; the quotient stays below 2^16.
    for (genvar gs = 1; gs <= LYI_Q_STEPS; gs++) begin : g_step
        localparam int B = LYI_Q_STEPS - gs;
        logic [LYI_NUM_W-1:0] w_trial;
        logic                 w_ge;

        assign w_trial = LYI_NUM_W'(r_den[gs-1]) << B;
        assign w_ge    = (r_num[gs-1] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[gs] <= w_ge ? (r_num[gs-1] - w_trial) : r_num[gs-1];
            end
        end

        if (gs < LYI_Q_STEPS) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) r_den[gs] <= r_den[gs-1];
            end
        end

        if (gs == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) r_quo[gs] <= LYI_Y_W'(w_ge);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) r_quo[gs] <= {r_quo[gs-1][LYI_Y_W-2:0], w_ge};
            end
        end
    end

    assign o_quot = r_quo[LYI_Q_STEPS];

endmodule

>>> src/lyi_lane.sv
// Yield pipeline for one recoil energy: log, two powers, g, k*g and division.
`timescale 1ns / 1ps

module lyi_lane #(
    parameter int ENERGY_BITS     = lyi_pkg::LYI_ENERGY_BITS,
    parameter int LOG_TABLE_DEPTH = lyi_pkg::LYI_LOG_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ENERGY_BITS-1:0]     i_energy,
    input  lyi_pkg::t_cfg              i_cfg,
    output logic [lyi_pkg::LYI_Y_W-1:0] o_yield
);
    import lyi_pkg::*;

    localparam int P_W   = ENERGY_BITS + 24;
    localparam int N_W   = $clog2(P_W);
    localparam int IDX_W = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int S_W   = 16 + IDX_W;

    // Constant interpolation tables, worked out at elaboration.
    logic [LYI_LOG_W-1:0] w_log_tab [0:LOG_TABLE_DEPTH];
    logic [LYI_EXP_W-1:0] w_exp_tab [0:LOG_TABLE_DEPTH];

    for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++) begin : g_tab
        localparam int T = (gi * 65536) / LOG_TABLE_DEPTH;
        assign w_log_tab[gi] = lyi_log_entry(T);
        assign w_exp_tab[gi] = lyi_exp_entry(T);
    end

    // Values that ride along the pipeline.
    logic [LYI_G_W-1:0] r_pc   [3:13];
    logic               r_zero [2:14];

    // Stage 1: reduced energy in Q.32.
    logic [P_W-1:0] r_p1;
    always_ff @(posedge i_clk) begin
        if (i_en) r_p1 <= P_W'(i_energy) * P_W'(i_cfg.scale);
    end

    // Stage 2: position of the leading one.
    logic [N_W-1:0] w_n2;
    logic [N_W-1:0] r_n2;
    logic [P_W-1:0] r_p2;
    always_comb begin
        w_n2 = '0;
        for (int b = 0; b < P_W; b++) begin
            if (r_p1[b]) w_n2 = N_W'(b);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n2      <= w_n2;
            r_p2      <= r_p1;
        end
    end

    // Stage 3: the sixteen bits below the leading one.
    logic [P_W+15:0]   w_sh3;
    logic [15:0]       r_f3;
    logic signed [7:0] r_lgi3;
    assign w_sh3 = {r_p2, 16'd0} >> r_n2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f3      <= w_sh3[15:0];
            r_lgi3    <= $signed(8'(r_n2)) - 8'sd32;
        end
    end

    // Zero flag from stage 2 and capped energy term from stage 3, carried to the end.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[2] <= (r_p1 == '0);
            r_pc[3]   <= (64'(r_p2) > 64'(LYI_G_CAP)) ? LYI_G_CAP : LYI_G_W'(r_p2);
            for (int s = 4; s <= 13; s++) r_pc[s] <= r_pc[s-1];
            for (int s = 3; s <= 14; s++) r_zero[s] <= r_zero[s-1];
        end
    end

    // Stage 4: table index and remainder of the log lookup.
    logic [S_W-1:0]    w_s4;
    logic [IDX_W-1:0]  r_idx4;
    logic [15:0]       r_rem4;
    logic signed [7:0] r_lgi4;
    assign w_s4 = S_W'(r_f3) * S_W'(LOG_TABLE_DEPTH);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx4 <= w_s4[S_W-1:16];
            r_rem4 <= w_s4[15:0];
            r_lgi4 <= r_lgi3;
        end
    end

    // Stage 5: log table base and step; a falling step counts as zero.
    logic [LYI_LOG_W-1:0] w_lb5;
    logic [LYI_LOG_W-1:0] w_ln5;
    logic [LYI_LOG_W-1:0] r_base5;
    logic [LYI_LOG_W-1:0] r_diff5;
    logic [15:0]          r_rem5;
    logic signed [7:0]    r_lgi5;
    assign w_lb5 = w_log_tab[r_idx4];
    assign w_ln5 = w_log_tab[r_idx4 + 1'b1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base5 <= w_lb5;
            r_diff5 <= (w_ln5 > w_lb5) ? (w_ln5 - w_lb5) : '0;
            r_rem5  <= r_rem4;
            r_lgi5  <= r_lgi4;
        end
    end

    // Stage 6: log2 of the reduced energy in Q.16.
    logic [LYI_LOG_W-1:0]       w_lfr6;
    logic signed [LYI_LG_W-1:0] r_lg6;
    assign w_lfr6 = LYI_LOG_W'((34'(r_diff5) * 34'(r_rem5)) >> 16);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg6 <= $signed({r_lgi5, 16'd0}) + $signed({7'd0, r_base5})
                   + $signed({7'd0, w_lfr6});
        end
    end

    // Stages 7 to 13: one power term for each exponent.
    logic [LYI_G_W-1:0] w_term [0:1];

    for (genvar gp = 0; gp < 2; gp++) begin : g_pow
        logic [15:0]                w_pexp;
        logic [15:0]                w_coef;
        logic signed [40:0]         w_prod7;
        logic signed [LYI_V_W-1:0]  r_v7;
        logic [S_W-1:0]             w_s8;
        logic [IDX_W-1:0]           r_idx8;
        logic [15:0]                r_rem8;
        logic signed [LYI_IP_W-1:0] r_ip8;
        logic [LYI_EXP_W-1:0]       w_xb9;
        logic [LYI_EXP_W-1:0]       w_xn9;
        logic [LYI_EXP_W-1:0]       r_base9;
        logic [LYI_EXP_W-1:0]       r_diff9;
        logic [15:0]                r_rem9;
        logic signed [LYI_IP_W-1:0] r_ip9;
        logic [LYI_EXP_W-1:0]       r_m10;
        logic signed [LYI_IP_W-1:0] r_ip10;
        logic signed [9:0]          w_sh11;
        logic [LYI_PWR_W-1:0]       r_pw11;
        logic [40:0]                r_ph12;
        logic [47:0]                r_pl12;
        logic [72:0]                w_tot13;
        logic [60:0]                w_t13;
        logic [LYI_G_W-1:0]         r_t13;

        assign w_pexp = (gp == 0) ? i_cfg.power_a : i_cfg.power_b;
        assign w_coef = (gp == 0) ? i_cfg.coef_a : i_cfg.coef_b;

        // Stage 7: exponent times log, floored to Q.16.
        assign w_prod7 = $signed({25'd0, w_pexp}) * $signed({{17{r_lg6[LYI_LG_W-1]}}, r_lg6});
        always_ff @(posedge i_clk) begin
            if (i_en) r_v7 <= w_prod7[40:16];
        end

        // Stage 8: integer part and exp table position of the fraction.
        assign w_s8 = S_W'(r_v7[15:0]) * S_W'(LOG_TABLE_DEPTH);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_idx8 <= w_s8[S_W-1:16];
                r_rem8 <= w_s8[15:0];
                r_ip8  <= r_v7[LYI_V_W-1:16];
            end
        end

        // Stage 9: exp table base and step.
        assign w_xb9 = w_exp_tab[r_idx8];
        assign w_xn9 = w_exp_tab[r_idx8 + 1'b1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_base9 <= w_xb9;
                r_diff9 <= (w_xn9 > w_xb9) ? (w_xn9 - w_xb9) : '0;
                r_rem9  <= r_rem8;
                r_ip9   <= r_ip8;
            end
        end

        // Stage 10: interpolated mantissa in Q2.16.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m10  <= r_base9 + LYI_EXP_W'((34'(r_diff9) * 34'(r_rem9)) >> 16);
                r_ip10 <= r_ip9;
            end
        end

        // Stage 11: scale the mantissa by the integer part into Q.32.
        assign w_sh11 = {r_ip10[LYI_IP_W-1], r_ip10} + 10'sd16;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pw11 <= w_sh11[9] ? (LYI_PWR_W'(r_m10) >> 10'(-w_sh11))
                                    : (LYI_PWR_W'(r_m10) << 10'(w_sh11));
            end
        end

        // Stage 12: coefficient product in two partial products.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ph12 <= 41'(r_pw11[LYI_PWR_W-1:32]) * 41'(w_coef);
                r_pl12 <= 48'(r_pw11[31:0]) * 48'(w_coef);
            end
        end

        // Stage 13: join the partial products, drop the Q4.12 fraction and cap.
        assign w_tot13 = (73'(r_ph12) << 32) + 73'(r_pl12);
        assign w_t13   = w_tot13[72:12];
        always_ff @(posedge i_clk) begin
            if (i_en) r_t13 <= (w_t13 > 61'(LYI_G_CAP)) ? LYI_G_CAP : LYI_G_W'(w_t13);
        end

        assign w_term[gp] = r_t13;
    end

    // Stage 14: g as the sum of the three terms, capped.
    logic [LYI_G_W+1:0] w_g14;
    logic [LYI_G_W-1:0] r_g14;
    assign w_g14 = (LYI_G_W+2)'(w_term[0]) + (LYI_G_W+2)'(w_term[1]) + (LYI_G_W+2)'(r_pc[13]);
    always_ff @(posedge i_clk) begin
        if (i_en) r_g14 <= (w_g14 > (LYI_G_W+2)'(LYI_G_CAP)) ? LYI_G_CAP : LYI_G_W'(w_g14);
    end

    // Stage 15: k*g; a zero reduced energy forces a zero yield.
    logic [LYI_KG_W-1:0] r_kg15;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kg15 <= r_zero[14] ? '0 : (LYI_KG_W'(r_g14[LYI_G_W-1:16]) * LYI_KG_W'(i_cfg.k));
        end
    end

    // Remaining stages: the divider.
    lyi_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_kg   (r_kg15),
        .o_quot (o_yield)
    );

endmodule

>>> src/lindhard_ionization_yield.sv
// Top level of the Lindhard ionization yield block: register port, pipeline and output buffer.
//
//  Channel   Handshake             Payload
//  config    psel/penable/pready   paddr, pwdata, prdata (32-bit registers at 4*i)
//  input     i_valid / o_stall     i_start_energy, i_end_energy
//  output    o_valid / i_stall     o_start_yield, o_end_yield, o_ionization_energy,
//                                  o_order_error
//
// One item enters per cycle unless the pipeline is halted; results go through the lanes,
// the deposit stage and the output register. The depth is set by the sixteen single-bit
// steps of the yield divider and the fifteen datapath stages ahead of it.
// Reset is synchronous and active low; it clears the stage valid bits and the output
// buffer valid bits, and loads the register defaults.
// A two-entry output buffer takes results while the output is stalled; the pipeline
// halts as a whole only once both entries are full.
`timescale 1ns / 1ps

module lindhard_ionization_yield #(
    parameter int ENERGY_BITS     = lyi_pkg::LYI_ENERGY_BITS,
    parameter int LOG_TABLE_DEPTH = lyi_pkg::LYI_LOG_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lyi_pkg::LYI_ADDR_W-1:0]  paddr,
    input  logic [lyi_pkg::LYI_DATA_W-1:0]  pwdata,
    output logic [lyi_pkg::LYI_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ENERGY_BITS-1:0]          i_start_energy,
    input  logic [ENERGY_BITS-1:0]          i_end_energy,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [lyi_pkg::LYI_Y_W-1:0]     o_start_yield,
    output logic [lyi_pkg::LYI_Y_W-1:0]     o_end_yield,
    output logic [lyi_pkg::LYI_DEP_W-1:0]   o_ionization_energy,
    output logic                            o_order_error
);
    import lyi_pkg::*;
    `include "assert_macros.svh"

    localparam int LAT = LYI_LANE_LAT;
    localparam int A_W = ENERGY_BITS + LYI_Y_W;

    // Configuration registers.
    t_cfg     r_cfg;
    t_reg_idx w_reg;
    assign w_reg  = t_reg_idx'(paddr[LYI_ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k       <= LYI_K_RST;
            r_cfg.scale   <= LYI_SCALE_RST;
            r_cfg.coef_a  <= LYI_COEF_A_RST;
            r_cfg.power_a <= LYI_POWER_A_RST;
            r_cfg.coef_b  <= LYI_COEF_B_RST;
            r_cfg.power_b <= LYI_POWER_B_RST;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                LYI_REG_K:       r_cfg.k       <= pwdata[15:0];
                LYI_REG_SCALE:   r_cfg.scale   <= pwdata[23:0];
                LYI_REG_COEF_A:  r_cfg.coef_a  <= pwdata[15:0];
                LYI_REG_POWER_A: r_cfg.power_a <= pwdata[15:0];
                LYI_REG_COEF_B:  r_cfg.coef_b  <= pwdata[15:0];
                LYI_REG_POWER_B: r_cfg.power_b <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read data.
    always_comb begin
        case (w_reg)
            LYI_REG_K:       prdata = LYI_DATA_W'(r_cfg.k);
            LYI_REG_SCALE:   prdata = LYI_DATA_W'(r_cfg.scale);
            LYI_REG_COEF_A:  prdata = LYI_DATA_W'(r_cfg.coef_a);
            LYI_REG_POWER_A: prdata = LYI_DATA_W'(r_cfg.power_a);
            LYI_REG_COEF_B:  prdata = LYI_DATA_W'(r_cfg.coef_b);
            LYI_REG_POWER_B: prdata = LYI_DATA_W'(r_cfg.power_b);
            default:         prdata = '0;
        endcase
    end

    // Pipeline advance: everything moves unless both output entries are taken.
    logic    r_ov;
    logic    r_sv;
    logic    w_en;
    assign w_en    = !(r_ov && r_sv);
    assign o_stall = !w_en;

    // Stage valid bits and the energies that travel beside the lanes.
    logic                   r_v  [1:LAT+1];
    logic [ENERGY_BITS-1:0] r_e0 [1:LAT];
    logic [ENERGY_BITS-1:0] r_e1 [1:LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAT + 1; s++) r_v[s] <= 1'b0;
        end else if (w_en) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= LAT + 1; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e0[1] <= i_start_energy;
            r_e1[1] <= i_end_energy;
            for (int s = 2; s <= LAT; s++) begin
                r_e0[s] <= r_e0[s-1];
                r_e1[s] <= r_e1[s-1];
            end
        end
    end

    // Yield lanes for the start and end energies.
    logic [LYI_Y_W-1:0] w_y0;
    logic [LYI_Y_W-1:0] w_y1;

    lyi_lane #(
        .ENERGY_BITS     (ENERGY_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_lane_start (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_energy (i_start_energy),
        .i_cfg    (r_cfg),
        .o_yield  (w_y0)
    );

    lyi_lane #(
        .ENERGY_BITS     (ENERGY_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_lane_end (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_energy (i_end_energy),
        .i_cfg    (r_cfg),
        .o_yield  (w_y1)
    );

    // Deposit stage: energy times yield at both ends and the order check.
    logic [A_W-1:0]     r_a0;
    logic [A_W-1:0]     r_a1;
    logic [LYI_Y_W-1:0] r_y0;
    logic [LYI_Y_W-1:0] r_y1;
    logic               r_err;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0  <= A_W'(r_e0[LAT]) * A_W'(w_y0);
            r_a1  <= A_W'(r_e1[LAT]) * A_W'(w_y1);
            r_y0  <= w_y0;
            r_y1  <= w_y1;
            r_err <= (r_e1[LAT] > r_e0[LAT]);
        end
    end

    // Deposited energy in Q.8, saturated; zero on wrong order or rounding inversion.
    logic [A_W-1:0] w_diff;
    logic [A_W-9:0] w_shr;
    t_result        w_res;
    assign w_diff = r_a0 - r_a1;
    assign w_shr  = w_diff[A_W-1:8];
    always_comb begin
        w_res.start_yield = r_y0;
        w_res.end_yield   = r_y1;
        w_res.err         = r_err;
        if (r_err || (r_a0 <= r_a1)) begin
            w_res.dep = '0;
        end else if (64'(w_shr) > 64'(LYI_DEP_MAX)) begin
            w_res.dep = LYI_DEP_MAX;
        end else begin
            w_res.dep = LYI_DEP_W'(w_shr);
        end
    end

    // Two-entry output buffer: the output register and a skid entry behind it.
    t_result r_out;
    t_result r_skid;
    logic    w_push;
    logic    w_pop;
    logic    n_ov;
    logic    n_sv;
    logic    w_out_load;
    logic    w_out_from_skid;
    logic    w_skid_load;

    assign w_push = w_en && r_v[LAT+1];
    assign w_pop  = r_ov && !i_stall;

    always_comb begin
        n_ov            = r_ov;
        n_sv            = r_sv;
        w_out_load      = 1'b0;
        w_out_from_skid = 1'b0;
        w_skid_load     = 1'b0;
        if (!r_ov || w_pop) begin
            if (r_sv) begin
                w_out_from_skid = 1'b1;
                n_ov            = 1'b1;
                n_sv            = w_push;
                w_skid_load     = w_push;
            end else begin
                w_out_load = w_push;
                n_ov       = w_push;
            end
        end else if (w_push) begin
            w_skid_load = 1'b1;
            n_sv        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) r_out <= r_skid;
        else if (w_out_load) r_out <= w_res;
        if (w_skid_load) r_skid <= w_res;
    end

    assign o_valid             = r_ov;
    assign o_start_yield       = r_out.start_yield;
    assign o_end_yield         = r_out.end_yield;
    assign o_ionization_energy = r_out.dep;
    assign o_order_error       = r_out.err;

    // The skid entry is only ever used behind a full output register.
    `LYI_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sv |-> r_ov, "skid entry holds a result while the output register is empty")
    // The skid entry fills only after a stalled output.
    `LYI_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_sv) |-> $past(r_ov && i_stall), "skid entry filled without a stalled output")
    // A wrong energy order never reports a deposit.
    `LYI_ASSERT(a_order_zero_dep, i_clk, i_rst_n, (o_valid && o_order_error) |-> (o_ionization_energy == '0), "deposit reported for a wrong energy order")

endmodule
